@@ rtl/bfscc_pkg.sv @@
// package for the bus frame sync and crc checker
// holds frame constants, status codes and the crc-16 byte update
// no dependencies
package bfscc_pkg;

  // frame sync pair and opcodes that carry a reading
  localparam logic [7:0] SYNC_FIRST      = 8'hA0;
  localparam logic [7:0] SYNC_SECOND     = 8'h00;
  localparam logic [7:0] OP_TEMPERATURE  = 8'h55;
  localparam logic [7:0] OP_SENSOR_VALUE = 8'h1A;

  // longest payload accepted before a frame is abandoned
  localparam logic [7:0] MAX_PAYLOAD = 8'd124;

  // crc-16/mcrf4xx, reflected
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // payload byte positions (frame byte minus four)
  localparam int unsigned HDR_BYTES  = 7;
  localparam logic [7:0]  IDX_SUBOP  = 8'd6;
  localparam logic [7:0]  IDX_RD_HI  = 8'd11;
  localparam logic [7:0]  IDX_RD_LO  = 8'd12;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_CRC_BAD = 2'd1,
    STAT_TOO_LONG = 2'd2
  } status_t;

  // one byte through the reflected crc, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // crc after the two sync bytes
  localparam logic [15:0] CRC_AFTER_SYNC = crc_byte(crc_byte(CRC_INIT, SYNC_FIRST), SYNC_SECOND);

endpackage

@@ rtl/bus_frame_sync_crc_checker_unit.sv @@
// top level of the bus frame sync and crc checker
// deframes bus bytes, checks crc-16/mcrf4xx and reports one result per frame
// depends on bfscc_pkg
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | in_rx_byte
//  out_    | output    | out_valid / out_ready| status, header fields, reading, crc
//
// one byte is taken per cycle while in_ready is high; phase, crc and header
// fields update at the transfer, and the result register loads in the same edge.
// a frame result shows in the cycle after its last byte (crc low or length byte).
// in_ready drops only while a result is held and out_ready is low.
// rst_n is synchronous, active low, and returns the block to the sync hunt.
module bus_frame_sync_crc_checker_unit #(
  parameter logic [7:0] MAX_PAYLOAD = bfscc_pkg::MAX_PAYLOAD
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_frame_opcode,
  output logic [7:0]  out_payload_length,
  output logic [15:0] out_source_address,
  output logic [7:0]  out_source_access,
  output logic [15:0] out_dest_address,
  output logic [7:0]  out_dest_access,
  output logic [7:0]  out_sub_opcode,
  output logic [15:0] out_reading,
  output logic [15:0] out_computed_crc
);

  typedef enum logic [2:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_OPCODE,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CRCHI,
    PH_CRCLO
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [7:0]  hdr_r [bfscc_pkg::HDR_BYTES];
  logic [7:0]  hdr_nxt [bfscc_pkg::HDR_BYTES];
  logic [15:0] rd_r, rd_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [7:0]  o_op_r, o_op_nxt;
  logic [7:0]  o_len_r, o_len_nxt;
  logic [15:0] o_src_r, o_src_nxt;
  logic [7:0]  o_src_acc_r, o_src_acc_nxt;
  logic [15:0] o_dst_r, o_dst_nxt;
  logic [7:0]  o_dst_acc_r, o_dst_acc_nxt;
  logic [7:0]  o_sub_r, o_sub_nxt;
  logic [15:0] o_rd_r, o_rd_nxt;
  logic [15:0] o_crc_r, o_crc_nxt;

  logic        in_xfer;
  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [8:0]  idx_inc;
  logic        emit;
  logic        emit_full;

  // a new byte may enter whenever the output register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign b        = in_rx_byte;
  assign crc_upd  = bfscc_pkg::crc_byte(crc_r, b);
  assign idx_inc  = {1'b0, idx_r} + 9'd1;

  // frame state walk
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    len_nxt    = len_r;
    op_nxt     = op_r;
    hdr_nxt    = hdr_r;
    rd_nxt     = rd_r;
    crc_hi_nxt = crc_hi_r;
    emit       = 1'b0;
    emit_full  = 1'b0;
    status_nxt = status_r;
    if (in_xfer) begin
      unique case (phase_r)
        PH_HUNT0: begin
          if (b == bfscc_pkg::SYNC_FIRST) begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_HUNT1: begin
          if (b == bfscc_pkg::SYNC_SECOND) begin
            crc_nxt    = bfscc_pkg::CRC_AFTER_SYNC;
            idx_nxt    = '0;
            len_nxt    = '0;
            op_nxt     = '0;
            rd_nxt     = '0;
            crc_hi_nxt = '0;
            for (int i = 0; i < bfscc_pkg::HDR_BYTES; i++) begin
              hdr_nxt[i] = '0;
            end
            phase_nxt = PH_OPCODE;
          end else if (b != bfscc_pkg::SYNC_FIRST) begin
            phase_nxt = PH_HUNT0;
          end
        end
        PH_OPCODE: begin
          op_nxt    = b;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LENGTH;
        end
        PH_LENGTH: begin
          len_nxt = b;
          crc_nxt = crc_upd;
          idx_nxt = '0;
          if (b > MAX_PAYLOAD) begin
            emit       = 1'b1;
            status_nxt = bfscc_pkg::STAT_TOO_LONG;
            phase_nxt  = PH_HUNT0;
          end else if (b == 8'd0) begin
            phase_nxt = PH_CRCHI;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_nxt = crc_upd;
          if (idx_r <= bfscc_pkg::IDX_SUBOP) begin
            hdr_nxt[idx_r[2:0]] = b;
          end
          if (op_r == bfscc_pkg::OP_TEMPERATURE && idx_r == bfscc_pkg::IDX_SUBOP) begin
            rd_nxt = {8'h00, b};
          end
          if (op_r == bfscc_pkg::OP_SENSOR_VALUE) begin
            if (idx_r == bfscc_pkg::IDX_RD_HI) begin
              rd_nxt = {b, rd_r[7:0]};
            end else if (idx_r == bfscc_pkg::IDX_RD_LO) begin
              rd_nxt = {rd_r[15:8], b};
            end
          end
          idx_nxt = idx_inc[7:0];
          if (idx_inc >= {1'b0, len_r}) begin
            phase_nxt = PH_CRCHI;
          end
        end
        PH_CRCHI: begin
          crc_hi_nxt = b;
          phase_nxt  = PH_CRCLO;
        end
        PH_CRCLO: begin
          emit      = 1'b1;
          emit_full = 1'b1;
          if (crc_r[15:8] == crc_hi_r && crc_r[7:0] == b) begin
            status_nxt = bfscc_pkg::STAT_OK;
          end else begin
            status_nxt = bfscc_pkg::STAT_CRC_BAD;
          end
          phase_nxt = PH_HUNT0;
        end
        default: begin
          phase_nxt = PH_HUNT0;
        end
      endcase
    end
  end

  // result register load
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    o_op_nxt      = o_op_r;
    o_len_nxt     = o_len_r;
    o_src_nxt     = o_src_r;
    o_src_acc_nxt = o_src_acc_r;
    o_dst_nxt     = o_dst_r;
    o_dst_acc_nxt = o_dst_acc_r;
    o_sub_nxt     = o_sub_r;
    o_rd_nxt      = o_rd_r;
    o_crc_nxt     = o_crc_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      o_op_nxt      = op_nxt;
      o_len_nxt     = len_nxt;
      o_crc_nxt     = crc_nxt;
      if (emit_full) begin
        o_src_nxt     = {hdr_r[0], hdr_r[2]};
        o_src_acc_nxt = hdr_r[1];
        o_dst_nxt     = {hdr_r[5], hdr_r[4]};
        o_dst_acc_nxt = hdr_r[3];
        o_sub_nxt     = hdr_r[6];
        o_rd_nxt      = rd_r;
      end else begin
        o_src_nxt     = '0;
        o_src_acc_nxt = '0;
        o_dst_nxt     = '0;
        o_dst_acc_nxt = '0;
        o_sub_nxt     = '0;
        o_rd_nxt      = '0;
      end
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      crc_r       <= bfscc_pkg::CRC_INIT;
      len_r       <= '0;
      op_r        <= '0;
      rd_r        <= '0;
      crc_hi_r    <= '0;
      status_r    <= bfscc_pkg::STAT_OK;
      for (int i = 0; i < bfscc_pkg::HDR_BYTES; i++) begin
        hdr_r[i] <= '0;
      end
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      len_r       <= len_nxt;
      op_r        <= op_nxt;
      rd_r        <= rd_nxt;
      crc_hi_r    <= crc_hi_nxt;
      status_r    <= status_nxt;
      hdr_r       <= hdr_nxt;
    end
    o_op_r      <= o_op_nxt;
    o_len_r     <= o_len_nxt;
    o_src_r     <= o_src_nxt;
    o_src_acc_r <= o_src_acc_nxt;
    o_dst_r     <= o_dst_nxt;
    o_dst_acc_r <= o_dst_acc_nxt;
    o_sub_r     <= o_sub_nxt;
    o_rd_r      <= o_rd_nxt;
    o_crc_r     <= o_crc_nxt;
  end

  // result outputs
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_frame_opcode   = o_op_r;
  assign out_payload_length = o_len_r;
  assign out_source_address = o_src_r;
  assign out_source_access  = o_src_acc_r;
  assign out_dest_address   = o_dst_r;
  assign out_dest_access    = o_dst_acc_r;
  assign out_sub_opcode     = o_sub_r;
  assign out_reading        = o_rd_r;
  assign out_computed_crc   = o_crc_r;

endmodule

@@ verif/tb_top.sv @@
// testbench for bus_frame_sync_crc_checker_unit: sends framed and noisy bus bytes,
// predicts each frame result with a local deframer and crc-16/mcrf4xx, checks every field
// depends on bfscc_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ITEM_TARGET = 1200;
  localparam int unsigned IDLE_PCT    = 6;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 8;

  // payload positions of the fields that build a reading
  localparam logic [7:0] POS_TEMP    = 8'd6;
  localparam logic [7:0] POS_READ_HI = 8'd11;
  localparam logic [7:0] POS_READ_LO = 8'd12;

  typedef enum logic [2:0] {
    HUNT_SYNC1, HUNT_SYNC2, TAKE_OPCODE, TAKE_LENGTH, TAKE_PAYLOAD, TAKE_CRC_HI, TAKE_CRC_LO
  } rx_phase_t;

  typedef enum int {CRC_GOOD, CRC_HI_BAD, CRC_LO_BAD, CRC_BOTH_BAD} crc_fault_t;

  typedef struct packed {
    bfscc_pkg::status_t status;
    logic [7:0]  opcode;
    logic [7:0]  length;
    logic [15:0] src_addr;
    logic [7:0]  src_access;
    logic [15:0] dst_addr;
    logic [7:0]  dst_access;
    logic [7:0]  sub_opcode;
    logic [15:0] reading;
    logic [15:0] crc;
  } frame_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_frame_opcode;
  logic [7:0]  out_payload_length;
  logic [15:0] out_source_address;
  logic [7:0]  out_source_access;
  logic [15:0] out_dest_address;
  logic [7:0]  out_dest_access;
  logic [7:0]  out_sub_opcode;
  logic [15:0] out_reading;
  logic [15:0] out_computed_crc;

  logic [7:0]    bus_bytes[$];
  frame_report_t expected_reports[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  logic          calm;

  // deframer state
  rx_phase_t   rx_phase = HUNT_SYNC1;
  logic [15:0] crc_acc = bfscc_pkg::CRC_INIT;
  logic [7:0]  pay_count = 8'h00;
  logic [7:0]  frame_len = 8'h00;
  logic [7:0]  frame_op = 8'h00;
  logic [7:0]  hdr[7] = '{default: 8'h00};
  logic [15:0] reading_acc = 16'h0000;
  logic [7:0]  crc_hi_rx = 8'h00;

  bus_frame_sync_crc_checker_unit #(
    .MAX_PAYLOAD (bfscc_pkg::MAX_PAYLOAD)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_frame_opcode   (out_frame_opcode),
    .out_payload_length (out_payload_length),
    .out_source_address (out_source_address),
    .out_source_access  (out_source_access),
    .out_dest_address   (out_dest_address),
    .out_dest_access    (out_dest_access),
    .out_sub_opcode     (out_sub_opcode),
    .out_reading        (out_reading),
    .out_computed_crc   (out_computed_crc)
  );

  always #5 clk = ~clk;

  // a stretch of the run with no idling on either side
  assign calm = (cycle_count >= 400) && (cycle_count < 800);

  // reflected crc-16, one byte lsb first
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    r = acc ^ {8'h00, data};
    repeat (8) r = r[0] ? ((r >> 1) ^ bfscc_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic frame_report_t frame_report(input bfscc_pkg::status_t st, input bit full);
    frame_report_t rep;
    rep.status     = st;
    rep.opcode     = frame_op;
    rep.length     = frame_len;
    rep.crc        = crc_acc;
    rep.src_addr   = full ? {hdr[0], hdr[2]} : 16'h0000;
    rep.src_access = full ? hdr[1] : 8'h00;
    rep.dst_addr   = full ? {hdr[5], hdr[4]} : 16'h0000;
    rep.dst_access = full ? hdr[3] : 8'h00;
    rep.sub_opcode = full ? hdr[6] : 8'h00;
    rep.reading    = full ? reading_acc : 16'h0000;
    return rep;
  endfunction

  // advance the deframer by one accepted byte, queue a result at frame end
  task automatic deframe_byte(input logic [7:0] b);
    case (rx_phase)
      HUNT_SYNC1: begin
        if (b == bfscc_pkg::SYNC_FIRST) rx_phase = HUNT_SYNC2;
      end
      HUNT_SYNC2: begin
        if (b == bfscc_pkg::SYNC_SECOND) begin
          crc_acc     = crc16_step(crc16_step(bfscc_pkg::CRC_INIT, bfscc_pkg::SYNC_FIRST),
                                   bfscc_pkg::SYNC_SECOND);
          pay_count   = 8'h00;
          frame_len   = 8'h00;
          frame_op    = 8'h00;
          hdr         = '{default: 8'h00};
          reading_acc = 16'h0000;
          crc_hi_rx   = 8'h00;
          rx_phase    = TAKE_OPCODE;
        end else if (b != bfscc_pkg::SYNC_FIRST) begin
          rx_phase = HUNT_SYNC1;
        end
      end
      TAKE_OPCODE: begin
        frame_op = b;
        crc_acc  = crc16_step(crc_acc, b);
        rx_phase = TAKE_LENGTH;
      end
      TAKE_LENGTH: begin
        frame_len = b;
        crc_acc   = crc16_step(crc_acc, b);
        if (b > bfscc_pkg::MAX_PAYLOAD) begin
          expected_reports.push_back(frame_report(bfscc_pkg::STAT_TOO_LONG, 1'b0));
          rx_phase = HUNT_SYNC1;
        end else begin
          pay_count = 8'h00;
          rx_phase  = (b == 8'h00) ? TAKE_CRC_HI : TAKE_PAYLOAD;
        end
      end
      TAKE_PAYLOAD: begin
        crc_acc = crc16_step(crc_acc, b);
        if (pay_count < 8'd7) hdr[pay_count[2:0]] = b;
        if (frame_op == bfscc_pkg::OP_TEMPERATURE && pay_count == POS_TEMP)
          reading_acc = {8'h00, b};
        if (frame_op == bfscc_pkg::OP_SENSOR_VALUE) begin
          if (pay_count == POS_READ_HI) reading_acc[15:8] = b;
          else if (pay_count == POS_READ_LO) reading_acc[7:0] = b;
        end
        pay_count = pay_count + 8'd1;
        if (pay_count >= frame_len) rx_phase = TAKE_CRC_HI;
      end
      TAKE_CRC_HI: begin
        crc_hi_rx = b;
        rx_phase  = TAKE_CRC_LO;
      end
      default: begin
        // both crc bytes must match for a good frame
        if (crc_acc[15:8] == crc_hi_rx && crc_acc[7:0] == b)
          expected_reports.push_back(frame_report(bfscc_pkg::STAT_OK, 1'b1));
        else
          expected_reports.push_back(frame_report(bfscc_pkg::STAT_CRC_BAD, 1'b1));
        rx_phase = HUNT_SYNC1;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_report(input frame_report_t got);
    frame_report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: result with none expected, expected nothing actual status %0d crc %h",
               $time, got.status, got.crc);
      error_count++;
    end else begin
      want = expected_reports.pop_front();
      check_field("status", 16'(want.status), 16'(got.status));
      check_field("frame_opcode", 16'(want.opcode), 16'(got.opcode));
      check_field("payload_length", 16'(want.length), 16'(got.length));
      check_field("source_address", want.src_addr, got.src_addr);
      check_field("source_access", 16'(want.src_access), 16'(got.src_access));
      check_field("dest_address", want.dst_addr, got.dst_addr);
      check_field("dest_access", 16'(want.dst_access), 16'(got.dst_access));
      check_field("sub_opcode", 16'(want.sub_opcode), 16'(got.sub_opcode));
      check_field("reading", want.reading, got.reading);
      check_field("computed_crc", want.crc, got.crc);
    end
  endtask

  // sync pair, header, payload and crc, with optional corruption of either or both crc bytes
  task automatic queue_frame(input logic [7:0] opcode, input logic [7:0] payload[$],
                             input crc_fault_t fault);
    logic [15:0] crc;
    logic [7:0]  hi;
    logic [7:0]  lo;
    crc = crc16_step(crc16_step(bfscc_pkg::CRC_INIT, bfscc_pkg::SYNC_FIRST),
                     bfscc_pkg::SYNC_SECOND);
    crc = crc16_step(crc, opcode);
    crc = crc16_step(crc, 8'(payload.size()));
    foreach (payload[i]) crc = crc16_step(crc, payload[i]);
    hi = crc[15:8];
    lo = crc[7:0];
    if (fault == CRC_HI_BAD || fault == CRC_BOTH_BAD) hi ^= 8'($urandom_range(255, 1));
    if (fault == CRC_LO_BAD || fault == CRC_BOTH_BAD) lo ^= 8'($urandom_range(255, 1));
    bus_bytes.push_back(bfscc_pkg::SYNC_FIRST);
    bus_bytes.push_back(bfscc_pkg::SYNC_SECOND);
    bus_bytes.push_back(opcode);
    bus_bytes.push_back(8'(payload.size()));
    foreach (payload[i]) bus_bytes.push_back(payload[i]);
    bus_bytes.push_back(hi);
    bus_bytes.push_back(lo);
  endtask

  task automatic queue_random_frame();
    logic [7:0]  payload[$];
    logic [7:0]  opcode;
    int unsigned len;
    int unsigned pick;
    crc_fault_t  fault;
    pick = $urandom_range(99);
    if (pick < 30) opcode = bfscc_pkg::OP_TEMPERATURE;
    else if (pick < 60) opcode = bfscc_pkg::OP_SENSOR_VALUE;
    else opcode = 8'($urandom);
    // mostly short frames, some that reach the reading bytes, a few at the limit
    pick = $urandom_range(99);
    if (pick < 10) len = 0;
    else if (pick < 55) len = $urandom_range(12, 1);
    else if (pick < 80) len = $urandom_range(20, 13);
    else if (pick < 86) len = bfscc_pkg::MAX_PAYLOAD;
    else if (pick < 90) len = $urandom_range(bfscc_pkg::MAX_PAYLOAD, bfscc_pkg::MAX_PAYLOAD - 3);
    else len = $urandom_range(60, 21);
    repeat (len) payload.push_back(8'($urandom));
    pick = $urandom_range(99);
    if (pick < 70) fault = CRC_GOOD;
    else if (pick < 80) fault = CRC_HI_BAD;
    else if (pick < 90) fault = CRC_LO_BAD;
    else fault = CRC_BOTH_BAD;
    queue_frame(opcode, payload, fault);
  endtask

  // cycle count and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // input driver, predicts each byte at its transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) deframe_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (bus_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid   <= 1'b1;
          in_rx_byte <= bus_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        check_report(frame_report_t'{status: bfscc_pkg::status_t'(out_status),
                                     opcode: out_frame_opcode,
                                     length: out_payload_length,
                                     src_addr: out_source_address,
                                     src_access: out_source_access,
                                     dst_addr: out_dest_address,
                                     dst_access: out_dest_access,
                                     sub_opcode: out_sub_opcode,
                                     reading: out_reading, crc: out_computed_crc});
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned pick;
    // hunt noise and a broken sync pair
    bus_bytes = '{8'hFF, bfscc_pkg::SYNC_FIRST, 8'h55, 8'h00};
    // repeated first sync byte, then a zero length frame
    bus_bytes.push_back(bfscc_pkg::SYNC_FIRST);
    queue_frame(bfscc_pkg::OP_SENSOR_VALUE, '{}, CRC_GOOD);
    // length just above the limit
    bus_bytes.push_back(bfscc_pkg::SYNC_FIRST);
    bus_bytes.push_back(bfscc_pkg::SYNC_SECOND);
    bus_bytes.push_back(bfscc_pkg::OP_TEMPERATURE);
    bus_bytes.push_back(bfscc_pkg::MAX_PAYLOAD + 8'd1);
    // sync byte inside the payload, crc high byte right and low byte wrong
    queue_frame(8'hFF, '{bfscc_pkg::SYNC_FIRST}, CRC_LO_BAD);

    while (bus_bytes.size() < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        queue_random_frame();
      end else if (pick < 92) begin
        bus_bytes.push_back(bfscc_pkg::SYNC_FIRST);
        bus_bytes.push_back(bfscc_pkg::SYNC_SECOND);
        bus_bytes.push_back(8'($urandom));
        bus_bytes.push_back(($urandom_range(99) < 30) ? bfscc_pkg::MAX_PAYLOAD + 8'd1 :
                            8'($urandom_range(255, bfscc_pkg::MAX_PAYLOAD + 1)));
      end else if (pick < 96) begin
        repeat ($urandom_range(4, 1)) bus_bytes.push_back(8'($urandom));
      end else begin
        bus_bytes.push_back(bfscc_pkg::SYNC_FIRST);
        bus_bytes.push_back(8'($urandom_range(255, 1)));
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (bus_bytes.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bfscc_pkg.sv
rtl/bus_frame_sync_crc_checker_unit.sv
verif/tb_top.sv
